// ----- hdl/counter_hash_stream_digest_macros.svh -----
`ifndef COUNTER_HASH_STREAM_DIGEST_MACROS_SVH
`define COUNTER_HASH_STREAM_DIGEST_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHSD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chsd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHSD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chsd check failed");

`endif

// ----- hdl/chsd_pkg.sv -----
package chsd_pkg;

    typedef enum logic [1:0] {
        CMD_STREAM = 2'd0,
        CMD_EVENT  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] index;
        logic [63:0] seed;
    } job_t;

    localparam logic [63:0] SEED_RESET = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    // prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_PRIME_LO = 64'h0000_0000_0000_01B3;
    localparam int          FNV_PRIME_SH = 40;
    localparam logic [10:0] EXP_OFS      = 11'd970;
    localparam logic [5:0]  MANT_TOP     = 6'd52;

endpackage

// ----- hdl/chsd_req_if.sv -----
interface chsd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] index;

    modport source (output valid, output command, output index, input ready);
    modport sink (input valid, input command, input index, output ready);
endinterface

// ----- hdl/chsd_cfg_if.sv -----
interface chsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/chsd_rsp_if.sv -----
interface chsd_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic [30:0] hash_top_bits;
    logic [63:0] unit_double_bits;
    logic [3:0]  event_bin;
    logic [4:0]  event_group;
    logic [7:0]  event_item;
    logic [63:0] digest;

    modport source (output valid, output hash_value, output hash_top_bits,
                    output unit_double_bits, output event_bin, output event_group,
                    output event_item, output digest, input ready);
    modport sink (input valid, input hash_value, input hash_top_bits,
                  input unit_double_bits, input event_bin, input event_group,
                  input event_item, input digest, output ready);
endinterface

// ----- hdl/counter_hash_stream_digest.sv -----
// Counter-mode splitmix64 hash stream with a running FNV-1a 64 digest. Each
// transfer on req carries a command and an index and yields exactly one
// transfer on rsp, in order. Items are taken one at a time by the back end;
// a queue of QUEUE_DEPTH entries in front of it keeps req ready while an item
// is in work, and the result register lets the next item start while a result
// waits. A stream item runs two mix rounds on one shared 32x32 multiplier,
// a leading-one search for the double, and byte-serial digest folding of
// three words. An event item runs three hash passes and folds one packed
// word; clear and the unused command 3 go straight to the result. The seed
// written on cfg applies to items accepted on req afterwards.
module counter_hash_stream_digest #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    chsd_req_if.sink    req,
    chsd_cfg_if.sink    cfg,
    chsd_rsp_if.source  rsp
);

    chsd_pkg::job_t job;
    logic           job_valid;
    logic           job_ready;

    chsd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    chsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .rsp       (rsp)
    );

endmodule

// ----- hdl/chsd_front.sv -----
module chsd_front #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    chsd_req_if.sink         req,
    chsd_cfg_if.sink         cfg,
    output chsd_pkg::job_t   job,
    output logic             job_valid,
    input  logic             job_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    chsd_pkg::job_t   q_mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [63:0]      seed_reg;
    logic             push;
    logic             pop;
    chsd_pkg::job_t   entry;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
        begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign cfg.ready = 1'b1;
    assign req.ready = (count_reg != CW'(DEPTH));
    assign push      = req.valid && req.ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_valid && job_ready;
    assign job       = q_mem_reg[rd_ptr_reg];

    // classify the command and capture the seed in force at the transfer
    always_comb
    begin
        entry.cmd   = chsd_pkg::cmd_t'(req.command);
        entry.index = req.index;
        entry.seed  = seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= chsd_pkg::SEED_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                seed_reg <= cfg.data;
            end
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ----- hdl/chsd_back.sv -----
module chsd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  chsd_pkg::job_t   job,
    input  logic             job_valid,
    output logic             job_ready,
    chsd_rsp_if.source       rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_IN,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MIX_MID,
        ST_NORM,
        ST_FOLD,
        ST_DONE
    } state_t;

    state_t          state_reg;
    chsd_pkg::job_t  job_reg;
    logic [63:0]     z_reg;
    logic [63:0]     acc_reg;
    logic            round_reg;
    logic [1:0]      ev_sel_reg;
    logic [63:0]     h_reg;
    logic [63:0]     dbl_reg;
    logic [3:0]      bin_reg;
    logic [4:0]      grp_reg;
    logic [7:0]      itm_reg;
    logic [52:0]     mm_reg;
    logic [5:0]      p_reg;
    logic [1:0]      word_sel_reg;
    logic [2:0]      byte_cnt_reg;
    logic [63:0]     w_reg;
    logic [63:0]     digest_reg;
    logic            out_valid_reg;
    logic [63:0]     out_hash_reg;
    logic [30:0]     out_top_reg;
    logic [63:0]     out_dbl_reg;
    logic [3:0]      out_bin_reg;
    logic [4:0]      out_grp_reg;
    logic [7:0]      out_itm_reg;
    logic [63:0]     out_digest_reg;

    logic [63:0]     mix_src;
    logic [63:0]     mix_x;
    logic [63:0]     mul_b;
    logic [31:0]     mul_opa;
    logic [31:0]     mul_opb;
    logic [63:0]     prod;
    logic [63:0]     mix_res;
    logic [63:0]     fnv_t;
    logic [63:0]     digest_next;

    assign job_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (job_reg.cmd == chsd_pkg::CMD_STREAM)
        begin
            mix_src = job_reg.seed + job_reg.index;
        end
        else
        begin
            mix_src = job_reg.seed ^ ({job_reg.index[61:0], 2'b00} + {62'd0, ev_sel_reg});
        end
        mix_x = mix_src + chsd_pkg::GOLDEN;
    end

    // one 32x32 multiplier; the 64-bit low product takes three passes
    assign mul_b = round_reg ? chsd_pkg::MIX_C2 : chsd_pkg::MIX_C1;

    always_comb
    begin
        case (state_reg)
            ST_MUL1:
            begin
                mul_opa = z_reg[63:32];
                mul_opb = mul_b[31:0];
            end
            ST_MUL2:
            begin
                mul_opa = z_reg[31:0];
                mul_opb = mul_b[63:32];
            end
            default:
            begin
                mul_opa = z_reg[31:0];
                mul_opb = mul_b[31:0];
            end
        endcase
        prod = 64'(mul_opa) * 64'(mul_opb);
    end

    assign mix_res = acc_reg ^ (acc_reg >> 31);

    // one fnv-1a byte step, times prime as shift plus small constant
    assign fnv_t       = digest_reg ^ {56'd0, w_reg[7:0]};
    assign digest_next = (fnv_t * chsd_pkg::FNV_PRIME_LO) + (fnv_t << chsd_pkg::FNV_PRIME_SH);

    assign rsp.valid            = out_valid_reg;
    assign rsp.hash_value       = out_hash_reg;
    assign rsp.hash_top_bits    = out_top_reg;
    assign rsp.unit_double_bits = out_dbl_reg;
    assign rsp.event_bin        = out_bin_reg;
    assign rsp.event_group      = out_grp_reg;
    assign rsp.event_item       = out_itm_reg;
    assign rsp.digest           = out_digest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            digest_reg     <= chsd_pkg::FNV_BASIS;
            out_valid_reg  <= 1'b0;
            job_reg        <= '0;
            z_reg          <= '0;
            acc_reg        <= '0;
            round_reg      <= 1'b0;
            ev_sel_reg     <= '0;
            h_reg          <= '0;
            dbl_reg        <= '0;
            bin_reg        <= '0;
            grp_reg        <= '0;
            itm_reg        <= '0;
            mm_reg         <= '0;
            p_reg          <= '0;
            word_sel_reg   <= '0;
            byte_cnt_reg   <= '0;
            w_reg          <= '0;
            out_hash_reg   <= '0;
            out_top_reg    <= '0;
            out_dbl_reg    <= '0;
            out_bin_reg    <= '0;
            out_grp_reg    <= '0;
            out_itm_reg    <= '0;
            out_digest_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg    <= job;
                        ev_sel_reg <= '0;
                        h_reg      <= '0;
                        dbl_reg    <= '0;
                        bin_reg    <= '0;
                        grp_reg    <= '0;
                        itm_reg    <= '0;
                        case (job.cmd)
                            chsd_pkg::CMD_STREAM, chsd_pkg::CMD_EVENT:
                            begin
                                state_reg <= ST_MIX_IN;
                            end
                            chsd_pkg::CMD_CLEAR:
                            begin
                                digest_reg <= chsd_pkg::FNV_BASIS;
                                state_reg  <= ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MIX_IN:
                begin
                    z_reg     <= mix_x ^ (mix_x >> 30);
                    round_reg <= 1'b0;
                    state_reg <= ST_MUL0;
                end
                ST_MUL0:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    acc_reg   <= acc_reg + {prod[31:0], 32'd0};
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    acc_reg   <= acc_reg + {prod[31:0], 32'd0};
                    state_reg <= ST_MIX_MID;
                end
                ST_MIX_MID:
                begin
                    if (!round_reg)
                    begin
                        z_reg     <= acc_reg ^ (acc_reg >> 27);
                        round_reg <= 1'b1;
                        state_reg <= ST_MUL0;
                    end
                    else if (job_reg.cmd == chsd_pkg::CMD_STREAM)
                    begin
                        h_reg     <= mix_res;
                        mm_reg    <= mix_res[63:11];
                        p_reg     <= chsd_pkg::MANT_TOP;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        case (ev_sel_reg)
                            2'd0:
                            begin
                                bin_reg    <= mix_res[36:33];
                                ev_sel_reg <= 2'd1;
                                state_reg  <= ST_MIX_IN;
                            end
                            2'd1:
                            begin
                                grp_reg    <= mix_res[37:33];
                                ev_sel_reg <= 2'd2;
                                state_reg  <= ST_MIX_IN;
                            end
                            default:
                            begin
                                // packed word: item at 31:24, group at 12:8, bin at 3:0
                                itm_reg      <= mix_res[40:33];
                                w_reg        <= {32'd0, mix_res[40:33], 11'd0, grp_reg,
                                                 4'd0, bin_reg};
                                word_sel_reg <= 2'd2;
                                byte_cnt_reg <= '0;
                                state_reg    <= ST_FOLD;
                            end
                        endcase
                    end
                end
                ST_NORM:
                begin
                    if (mm_reg == '0 || mm_reg[52])
                    begin
                        if (mm_reg != '0)
                        begin
                            dbl_reg <= {1'b0, 11'(p_reg) + chsd_pkg::EXP_OFS, mm_reg[51:0]};
                        end
                        w_reg        <= h_reg;
                        word_sel_reg <= 2'd0;
                        byte_cnt_reg <= '0;
                        state_reg    <= ST_FOLD;
                    end
                    else if (mm_reg[52:45] == '0)
                    begin
                        mm_reg <= {mm_reg[44:0], 8'd0};
                        p_reg  <= p_reg - 6'd8;
                    end
                    else
                    begin
                        mm_reg <= {mm_reg[51:0], 1'b0};
                        p_reg  <= p_reg - 6'd1;
                    end
                end
                ST_FOLD:
                begin
                    digest_reg   <= digest_next;
                    w_reg        <= w_reg >> 8;
                    byte_cnt_reg <= byte_cnt_reg + 3'd1;
                    if (byte_cnt_reg == 3'd7)
                    begin
                        case (word_sel_reg)
                            2'd0:
                            begin
                                w_reg        <= {33'd0, h_reg[63:33]};
                                word_sel_reg <= 2'd1;
                            end
                            2'd1:
                            begin
                                w_reg        <= dbl_reg;
                                word_sel_reg <= 2'd2;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_hash_reg   <= h_reg;
                        out_top_reg    <= h_reg[63:33];
                        out_dbl_reg    <= dbl_reg;
                        out_bin_reg    <= bin_reg;
                        out_grp_reg    <= grp_reg;
                        out_itm_reg    <= itm_reg;
                        out_digest_reg <= digest_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/chsd_checker.sv -----
`include "counter_hash_stream_digest_macros.svh"

module chsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_value,
    input logic [30:0] hash_top_bits,
    input logic [63:0] unit_double_bits,
    input logic [3:0]  event_bin,
    input logic [4:0]  event_group,
    input logic [7:0]  event_item
);

    // a stalled result stays offered
    `CHSD_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid)

    // top bits always track the hash word
    `CHSD_ASSERT_NOW(a_top_bits, out_valid, hash_top_bits == hash_value[63:33])

    // event fields and stream fields never mix in one result
    `CHSD_ASSERT_NOW(a_event_only,
        out_valid && (event_bin != 4'd0 || event_group != 5'd0 || event_item != 8'd0),
        hash_value == 64'd0 && unit_double_bits == 64'd0)

    // double of a value below one: sign clear, exponent not equal to the bias
    `CHSD_ASSERT_NOW(a_dbl_range, out_valid,
        unit_double_bits[63] == 1'b0 && unit_double_bits[62:52] != 11'h3FF)

endmodule

bind counter_hash_stream_digest chsd_checker u_chsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .hash_value       (rsp.hash_value),
    .hash_top_bits    (rsp.hash_top_bits),
    .unit_double_bits (rsp.unit_double_bits),
    .event_bin        (rsp.event_bin),
    .event_group      (rsp.event_group),
    .event_item       (rsp.event_item)
);
